/* sv/bhq_pkg.sv */
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared constants, types and state codes for the binary min-heap queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int COORD_BITS = 8;
    localparam int KEY_BITS   = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = ADDR_W + 2;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_EX_LOAD,
        S_DOWN,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] column;
    } entry_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        entry_t              wdata;
        logic [ADDR_W-1:0]   raddr_a;
        logic [ADDR_W-1:0]   raddr_b;
    } ram_req_t;

    typedef struct packed {
        logic             ok;
        entry_t           entry;
        logic [CNT_W-1:0] fill;
    } rsp_t;

endpackage

/* sv/bhq_if.sv */
// ----------------------------------------------------------------------------
// bhq_req_if / bhq_rsp_if
// Valid/ready channels for heap requests and their responses.
// ----------------------------------------------------------------------------
interface bhq_req_if;
    import bhq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [KEY_BITS-1:0]   key_in;
    logic [COORD_BITS-1:0] row_in;
    logic [COORD_BITS-1:0] column_in;

    modport source (output valid, op, key_in, row_in, column_in, input ready);
    modport sink   (input valid, op, key_in, row_in, column_in, output ready);
endinterface

interface bhq_rsp_if;
    import bhq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [KEY_BITS-1:0]   key_out;
    logic [COORD_BITS-1:0] row_out;
    logic [COORD_BITS-1:0] column_out;
    logic [CNT_W-1:0]      fill;

    modport source (output valid, ok, key_out, row_out, column_out, fill, input ready);
    modport sink   (input valid, ok, key_out, row_out, column_out, fill, output ready);
endinterface

/* sv/bhq_ram.sv */
// ----------------------------------------------------------------------------
// bhq_ram
// Heap storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bhq_ram (
    input  logic              clk,
    input  bhq_pkg::ram_req_t ram_req,
    output bhq_pkg::entry_t   rd_a,
    output bhq_pkg::entry_t   rd_b
);
    import bhq_pkg::*;

    entry_t mem [CAPACITY];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[ram_req.raddr_a];
        rd_b_reg <= mem[ram_req.raddr_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

/* sv/bhq_out_reg.sv */
// ----------------------------------------------------------------------------
// bhq_out_reg
// Response register between the heap engine and the response channel.
// ----------------------------------------------------------------------------
module bhq_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  bhq_pkg::rsp_t res,
    input  logic          res_load,
    output logic          slot_free,
    bhq_rsp_if.source     rsp
);
    import bhq_pkg::*;

    logic valid_reg;
    rsp_t data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res;
        end
    end

    assign slot_free      = !valid_reg || rsp.ready;
    assign rsp.valid      = valid_reg;
    assign rsp.ok         = data_reg.ok;
    assign rsp.key_out    = data_reg.entry.key;
    assign rsp.row_out    = data_reg.entry.row;
    assign rsp.column_out = data_reg.entry.column;
    assign rsp.fill       = data_reg.fill;

endmodule

/* sv/bhq_ctrl.sv */
// ----------------------------------------------------------------------------
// bhq_ctrl
// Heap engine: insert with sift-up, extract-min with sift-down, one level
// per memory read round trip.
// ----------------------------------------------------------------------------
module bhq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    bhq_req_if.sink           req,
    output bhq_pkg::ram_req_t ram_req,
    input  bhq_pkg::entry_t   rd_a,
    input  bhq_pkg::entry_t   rd_b,
    input  logic              slot_free,
    output bhq_pkg::rsp_t     res,
    output logic              res_load
);
    import bhq_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    entry_t            mv_reg, mv_next;
    entry_t            top_reg, top_next;
    logic              ok_reg, ok_next;
    logic              wr_fin_reg, wr_fin_next;

    logic [ADDR_W-1:0] par_idx;
    logic [ADDR_W-1:0] gpar_idx;
    logic [ADDR_W-1:0] ins_par_idx;
    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
    logic [IDX_W-1:0]  n_ext;
    logic              pick_right;
    logic [ADDR_W-1:0] pick_idx;
    logic [IDX_W-1:0]  child_l;
    logic [IDX_W-1:0]  child_r;

    // index arithmetic
    assign par_idx     = (pos_reg - ADDR_W'(1)) >> 1;
    assign gpar_idx    = (par_idx - ADDR_W'(1)) >> 1;
    assign ins_par_idx = (cnt_reg[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
    assign left_idx    = {1'b0, pos_reg, 1'b1};
    assign right_idx   = left_idx + IDX_W'(1);
    assign n_ext       = IDX_W'(cnt_reg);
    assign pick_right  = !(rd_a.key < rd_b.key);
    assign pick_idx    = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    assign child_l     = {1'b0, pick_idx, 1'b1};
    assign child_r     = child_l + IDX_W'(1);

    assign req.ready = (state_reg == S_IDLE);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ok_reg     <= 1'b0;
            wr_fin_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ok_reg     <= ok_next;
            wr_fin_reg <= wr_fin_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        mv_reg  <= mv_next;
        top_reg <= top_next;
    end

    // next state, memory requests and response
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        mv_next        = mv_reg;
        top_next       = top_reg;
        ok_next        = ok_reg;
        wr_fin_next    = wr_fin_reg;
        ram_req        = '0;
        ram_req.wdata  = mv_reg;
        ram_req.waddr  = pos_reg;
        res_load       = 1'b0;
        res.ok         = ok_reg;
        res.entry      = top_reg;
        res.fill       = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    top_next = '0;
                    if (op_t'(req.op) == OP_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            ok_next     = 1'b0;
                            wr_fin_next = 1'b0;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            ok_next        = 1'b1;
                            mv_next.key    = req.key_in;
                            mv_next.row    = req.row_in;
                            mv_next.column = req.column_in;
                            pos_next       = cnt_reg[ADDR_W-1:0];
                            cnt_next       = cnt_reg + CNT_W'(1);
                            wr_fin_next    = 1'b1;
                            ram_req.raddr_a = ins_par_idx;
                            state_next     = (cnt_reg == '0) ? S_FIN : S_UP;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            ok_next     = 1'b0;
                            wr_fin_next = 1'b0;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            ok_next         = 1'b1;
                            ram_req.raddr_a = '0;
                            ram_req.raddr_b = cnt_reg[ADDR_W-1:0] - ADDR_W'(1);
                            cnt_next        = cnt_reg - CNT_W'(1);
                            state_next      = S_EX_LOAD;
                        end
                    end
                end
            end

            // parent read back: move it down or stop
            S_UP:
            begin
                if (mv_reg.key < rd_a.key)
                begin
                    ram_req.we      = 1'b1;
                    ram_req.wdata   = rd_a;
                    pos_next        = par_idx;
                    ram_req.raddr_a = gpar_idx;
                    if (par_idx == '0)
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // root and last entry read back
            S_EX_LOAD:
            begin
                top_next        = rd_a;
                mv_next         = rd_b;
                pos_next        = '0;
                ram_req.raddr_a = ADDR_W'(1);
                ram_req.raddr_b = ADDR_W'(2);
                if (cnt_reg == '0)
                begin
                    wr_fin_next = 1'b0;
                    state_next  = S_FIN;
                end
                else
                begin
                    wr_fin_next = 1'b1;
                    state_next  = S_DOWN;
                end
            end

            // children read back: pull the smaller one up or stop
            S_DOWN:
            begin
                if (right_idx < n_ext)
                begin
                    if (rd_b.key < mv_reg.key || rd_a.key < mv_reg.key)
                    begin
                        ram_req.we      = 1'b1;
                        ram_req.wdata   = pick_right ? rd_b : rd_a;
                        pos_next        = pick_idx;
                        ram_req.raddr_a = child_l[ADDR_W-1:0];
                        ram_req.raddr_b = child_r[ADDR_W-1:0];
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (left_idx < n_ext && rd_a.key < mv_reg.key)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = rd_a;
                    pos_next      = left_idx[ADDR_W-1:0];
                    state_next    = S_FIN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // place the moving entry and hand over the response
            S_FIN:
            begin
                ram_req.we = wr_fin_reg;
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=>
            (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + CNT_W'(1) ||
             cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_down_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN && ram_req.we && state_next == S_DOWN) |->
            (ram_req.waddr != ram_req.raddr_a && ram_req.waddr != ram_req.raddr_b))
        else $error("sift-down write overlaps a child read");

    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (state_reg == S_IDLE))
        else $error("response loaded without returning to idle");

    a_cnt_stable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (cnt_reg == $past(cnt_reg)))
        else $error("entry count changed mid-operation");
`endif

endmodule

/* sv/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Bounded min-heap priority queue with a row/column payload.
// ----------------------------------------------------------------------------
// channel | dir | contents
// req     | in  | op, key_in, row_in, column_in
// rsp     | out | ok, key_out, row_out, column_out, fill
//
// One request at a time; each request gives one response.
// Insert: sift-up compares the new entry with one parent per step.
// Extract: reads the root and last entry, then compares one node's children per step.
// Each heap level costs one read round trip of the heap memory.
// Reset clears the fill count and control state; heap memory needs no clearing.
// A stalled response holds the engine in its final state; the next request
// can be taken while the previous response waits in the output register.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
    input  logic      clk,
    input  logic      rst_n,
    bhq_req_if.sink   req,
    bhq_rsp_if.source rsp
);
    import bhq_pkg::*;

    ram_req_t ram_req;
    entry_t   rd_a;
    entry_t   rd_b;
    rsp_t     res;
    logic     res_load;
    logic     slot_free;

    // heap engine
    bhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_req   (ram_req),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .slot_free (slot_free),
        .res       (res),
        .res_load  (res_load)
    );

    // heap storage
    bhq_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rd_a    (rd_a),
        .rd_b    (rd_b)
    );

    // response register
    bhq_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_load  (res_load),
        .slot_free (slot_free),
        .rsp       (rsp)
    );

endmodule

/* dv/binary_min_heap_queue_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_test
// Self-checking bench for the min-heap queue: a directed table of inserts
// and extracts (empty heap, key extremes, equal keys) followed by random
// traffic up to capacity, checked against typed rows or a heap model
// kept in step with every accepted request, under four idling patterns.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_test;
    import bhq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIRECTED_N   = 21;
    localparam int MIXED_ITEMS  = 150;
    localparam int REFUSED_TRY  = 8;
    localparam int NEAR_FULL_N  = 40;

    typedef struct {
        op_t             op;
        logic [15:0]     key;
        logic [7:0]      row;
        logic [7:0]      column;
        bit              typed;
        logic            w_ok;
        logic [15:0]     w_key;
        logic [7:0]      w_row;
        logic [7:0]      w_column;
        logic [CNT_W-1:0] w_fill;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bhq_req_if req_ch ();
    bhq_rsp_if rsp_ch ();

    binary_min_heap_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // heap model and outstanding responses
    entry_t      heap_model [CAPACITY];
    int unsigned heap_count;
    rsp_t        pending_rsp [$];

    int sender_idle_pct;
    int stall_pct;
    int cycle_count;
    int fail_count;
    int request_count;
    int response_count;
    int refused_count;
    int empty_count;
    int peak_fill;

    // directed table: typed expectations only where obvious
    dir_row_t directed_rows [DIRECTED_N] = '{
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0, 11'd0},
        '{OP_INSERT,  16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd1},
        '{OP_INSERT,  16'h0000, 8'h00, 8'h00, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd2},
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b1, 16'h0000, 8'h00, 8'h00, 11'd1},
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 11'd0},
        '{OP_EXTRACT, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0, 11'd0},
        '{OP_INSERT,  16'd100,  8'h01, 8'h01, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd1},
        '{OP_INSERT,  16'd100,  8'h02, 8'h02, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd2},
        '{OP_INSERT,  16'd100,  8'h03, 8'h03, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd3},
        '{OP_INSERT,  16'd100,  8'h04, 8'h04, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd4},
        '{OP_INSERT,  16'd100,  8'h05, 8'h05, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd5},
        '{OP_INSERT,  16'd50,   8'hA5, 8'h5A, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd6},
        '{OP_INSERT,  16'd100,  8'h06, 8'h06, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd7},
        '{OP_INSERT,  16'hAAAA, 8'h55, 8'hAA, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd8},
        '{OP_INSERT,  16'h5555, 8'hAA, 8'h55, 1'b1, 1'b1, 16'h0, 8'h0, 8'h0, 11'd9},
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0, 11'd0},
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0, 11'd0},
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0, 11'd0},
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0, 11'd0},
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0, 11'd0},
        '{OP_EXTRACT, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0, 11'd0}
    };

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void swap_entries(int unsigned a, int unsigned b);
        entry_t t;
        t = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = t;
    endfunction

    // applies one request to the heap model and returns its response
    function automatic rsp_t predict_heap_op(op_t op, entry_t e);
        rsp_t        r;
        int unsigned pos;
        int unsigned up;
        int unsigned left;
        int unsigned pick;
        int unsigned n;
        r = '0;
        if (op == OP_INSERT)
        begin
            if (heap_count < CAPACITY)
            begin
                pos = heap_count;
                heap_model[pos] = e;
                // climb while strictly smaller than the parent
                while (pos != 0)
                begin
                    up = (pos - 1) / 2;
                    if (!(heap_model[pos].key < heap_model[up].key))
                        break;
                    swap_entries(pos, up);
                    pos = up;
                end
                heap_count++;
                r.ok = 1'b1;
            end
        end
        else if (heap_count != 0)
        begin
            r.ok    = 1'b1;
            r.entry = heap_model[0];
            n = heap_count - 1;
            heap_model[0] = heap_model[n];
            heap_count = n;
            pos  = 0;
            left = 1;
            // descend toward the smaller child, right child on a tie
            while (left + 1 < n &&
                   (heap_model[left + 1].key < heap_model[pos].key ||
                    heap_model[left].key < heap_model[pos].key))
            begin
                pick = (heap_model[left].key < heap_model[left + 1].key) ? left : left + 1;
                swap_entries(pos, pick);
                pos  = pick;
                left = 2 * pos + 1;
            end
            if (left < n && heap_model[left].key < heap_model[pos].key)
                swap_entries(pos, left);
        end
        r.fill = heap_count[CNT_W-1:0];
        return r;
    endfunction

    // keys: mostly full range, some crowded to force ties, some extremes
    function automatic logic [15:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
            return 16'($urandom_range(7));
        else if (sel < 31)
            return 16'h0000;
        else if (sel < 37)
            return 16'hFFFF;
        else
            return 16'($urandom_range(65535));
    endfunction

    // one request: optional idle gap, then hold valid until taken
    task automatic send_request(input op_t op, input logic [15:0] key,
                                input logic [7:0] row, input logic [7:0] column,
                                input bit typed, input rsp_t want);
        entry_t e;
        rsp_t   predicted;
        int     gap;
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.key_in    <= key;
        req_ch.row_in    <= row;
        req_ch.column_in <= column;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        e.key    = key;
        e.row    = row;
        e.column = column;
        predicted = predict_heap_op(op, e);
        pending_rsp.push_back(typed ? want : predicted);
        request_count++;
        if (op == OP_INSERT && !predicted.ok)
            refused_count++;
        if (op == OP_EXTRACT && !predicted.ok)
            empty_count++;
        if (heap_count > peak_fill)
            peak_fill = heap_count;
    endtask

    task automatic send_random(input op_t op);
        send_request(op, pick_key(), 8'($urandom_range(255)), 8'($urandom_range(255)),
                     1'b0, '0);
    endtask

    // set idling pattern for a phase
    task automatic set_idling(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 85; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 85; end
            default: begin sender_idle_pct = 24; stall_pct = 24; end
        endcase
    endtask

    // response side stalls
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // response checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            response_count++;
            if (pending_rsp.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] unexpected response: ok=%0b key=%h row=%h col=%h fill=%0d",
                             $realtime, rsp_ch.ok, rsp_ch.key_out, rsp_ch.row_out,
                             rsp_ch.column_out, rsp_ch.fill);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.ok !== want.ok || rsp_ch.key_out !== want.entry.key ||
                    rsp_ch.row_out !== want.entry.row ||
                    rsp_ch.column_out !== want.entry.column || rsp_ch.fill !== want.fill)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] response %0d mismatch: expected ok=%0b key=%h row=%h ",
                                 $realtime, response_count, want.ok, want.entry.key,
                                 want.entry.row,
                                 "col=%h fill=%0d, got ok=%0b key=%h row=%h col=%h fill=%0d",
                                 want.entry.column, want.fill, rsp_ch.ok,
                                 rsp_ch.key_out, rsp_ch.row_out, rsp_ch.column_out,
                                 rsp_ch.fill);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_rsp.size());
            $display("binary_min_heap_queue regression: fail");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rsp_t want;
        int   mode;
        int   i;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_INSERT;
        req_ch.key_in    = '0;
        req_ch.row_in    = '0;
        req_ch.column_in = '0;
        rsp_ch.ready     = 1'b0;
        rst_n            = 1'b0;
        heap_count       = 0;
        cycle_count      = 0;
        fail_count       = 0;
        request_count    = 0;
        response_count   = 0;
        refused_count    = 0;
        empty_count      = 0;
        peak_fill        = 0;
        set_idling(0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[k])
        begin
            want.ok           = directed_rows[k].w_ok;
            want.entry.key    = directed_rows[k].w_key;
            want.entry.row    = directed_rows[k].w_row;
            want.entry.column = directed_rows[k].w_column;
            want.fill         = directed_rows[k].w_fill;
            send_request(directed_rows[k].op, directed_rows[k].key, directed_rows[k].row,
                         directed_rows[k].column, directed_rows[k].typed, want);
        end

        // mixed traffic: grow the heap, then drain it past empty
        for (mode = 0; mode < 4; mode++)
        begin
            set_idling(mode);
            for (i = 0; i < MIXED_ITEMS; i++)
            begin
                if (i < MIXED_ITEMS / 2)
                    send_random(($urandom_range(99) < 70) ? OP_INSERT : OP_EXTRACT);
                else
                    send_random(($urandom_range(99) < 70) ? OP_EXTRACT : OP_INSERT);
            end
        end

        // fill to capacity, push against the full heap, then churn near full
        set_idling(0);
        while (heap_count < CAPACITY)
            send_random(OP_INSERT);
        set_idling(3);
        for (i = 0; i < REFUSED_TRY; i++)
            send_random(OP_INSERT);
        for (i = 0; i < NEAR_FULL_N; i++)
            send_random(($urandom_range(1) == 0) ? OP_INSERT : OP_EXTRACT);
        req_ch.valid <= 1'b0;

        // drain outstanding responses
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d refused inserts, %0d empty extracts, peak fill %0d",
                 request_count, refused_count, empty_count, peak_fill);
        $display("%0d responses checked, %0d failures, %0d cycles",
                 response_count, fail_count, cycle_count);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("binary_min_heap_queue regression: pass");
        else
            $display("binary_min_heap_queue regression: fail");
        $finish;
    end

endmodule
